@@ src/positional_list_engine_unit_macros.svh @@
// Assertion macros for the RTL of the positional list engine.
`ifndef POSITIONAL_LIST_ENGINE_UNIT_MACROS_SVH
`define POSITIONAL_LIST_ENGINE_UNIT_MACROS_SVH
`ifndef SYNTH
`define PLIST_ASSERT(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (prop)) else $error(msg);
`define PLIST_ASSERT_NEXT(lbl, pre, post, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (pre) |=> (post)) else $error(msg);
`else
`define PLIST_ASSERT(lbl, prop, msg)
`define PLIST_ASSERT_NEXT(lbl, pre, post, msg)
`endif
`endif

@@ src/plist_pkg.sv @@
`default_nettype none
package plist_pkg;
   localparam int WORD_W = 32;

   localparam logic [1:0] OP_INSERT = 2'd0;
   localparam logic [1:0] OP_REMOVE = 2'd1;
   localparam logic [1:0] OP_QUERY  = 2'd2;
   localparam logic [1:0] OP_DUMP   = 2'd3;

   localparam logic [1:0] ST_DONE  = 2'd0;
   localparam logic [1:0] ST_RANGE = 2'd1;
   localparam logic [1:0] ST_FULL  = 2'd2;

   typedef struct packed {
      logic ins;
      logic rem;
   } cell_ctrl_type;
endpackage
`default_nettype wire

@@ src/plist_cell.sv @@
`default_nettype none
module plist_cell #(
   parameter int INDEX = 0,
   parameter int IW    = 7
) (
   input  logic                           clock,
   input  plist_pkg::cell_ctrl_type       ctrl,
   input  logic [IW-1:0]                  pos,
   input  logic [IW-1:0]                  rd_idx,
   input  logic [plist_pkg::WORD_W-1:0]   ins_value,
   input  logic [plist_pkg::WORD_W-1:0]   left_value,
   input  logic [plist_pkg::WORD_W-1:0]   right_value,
   output logic [plist_pkg::WORD_W-1:0]   value,
   output logic [plist_pkg::WORD_W-1:0]   sel_value
);
   import plist_pkg::*;

   localparam logic [IW-1:0] MY_INDEX = IW'(INDEX);

   logic [WORD_W-1:0] word_ff;
   logic [WORD_W-1:0] word_in;

   always_comb begin
      word_in = word_ff;
      if (ctrl.ins) begin
         if (pos == MY_INDEX) begin
            word_in = ins_value;
         end else if (MY_INDEX > pos) begin
            word_in = left_value;
         end
      end else if (ctrl.rem) begin
         if (MY_INDEX >= pos) begin
            word_in = right_value;
         end
      end
   end

   always_ff @(posedge clock) begin
      word_ff <= word_in;
   end

   assign value     = word_ff;
   assign sel_value = (rd_idx == MY_INDEX) ? word_ff : '0;
endmodule
`default_nettype wire

@@ src/positional_list_engine_unit.sv @@
`default_nettype none
// Ordered list of up to CAPACITY signed words held in a row of shifting cells.
// An insert, remove or query is taken when start is high and busy is low, and its
// single result beat appears on the rsp_ ports in the next cycle, so such commands
// may be issued every cycle while no dump runs. A dump keeps busy high while it
// reads the cells one by one: a list of N elements gives N result beats on
// consecutive cycles, and the next command can be taken in the cycle of the final
// beat; an empty list gives one beat without data. The receiver cannot stall, so
// every beat must be captured in the cycle in which rsp_strobe is high.
module positional_list_engine_unit #(
   parameter int CAPACITY = 64
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  logic [1:0]         req_operation,
   input  logic [6:0]         req_position,
   input  logic signed [31:0] req_value,
   output logic signed [31:0] rsp_data_value,
   output logic               rsp_data_valid,
   output logic [6:0]         rsp_list_length,
   output logic [1:0]         rsp_status,
   output logic               rsp_last_of_run,
   output logic               rsp_strobe
);
   import plist_pkg::*;

`include "positional_list_engine_unit_macros.svh"

   localparam int CW   = $clog2(CAPACITY + 1);
   localparam int IW   = (CW > 7) ? CW : 7;
   localparam int IDXW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;

   logic [CW-1:0]     count_ff, count_in;
   logic              dump_ff, dump_in;
   logic [IDXW-1:0]   idx_ff, idx_in;
   logic              strobe_ff, strobe_in;
   logic [WORD_W-1:0] data_ff, data_in;
   logic              valid_ff, valid_in;
   logic [6:0]        len_ff, len_in;
   logic [1:0]        status_ff, status_in;
   logic              last_ff, last_in;

   cell_ctrl_type     ctrl;
   logic              accept;
   logic [IW-1:0]     pos_ext, cnt_ext, idx_ext, rd_idx, len_wide;
   logic [WORD_W-1:0] sel_or;
   logic [WORD_W-1:0] cell_data [CAPACITY];
   logic [WORD_W-1:0] cell_sel  [CAPACITY];

   assign busy    = dump_ff;
   assign accept  = start && !dump_ff;
   assign pos_ext = IW'(req_position);
   assign cnt_ext = IW'(count_ff);
   assign idx_ext = IW'(idx_ff);
   assign rd_idx  = dump_ff ? idx_ext : pos_ext;

   for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
      logic [WORD_W-1:0] left_value;
      logic [WORD_W-1:0] right_value;
      if (g == 0) begin : g_first
         assign left_value = req_value;
      end else begin : g_inner_l
         assign left_value = cell_data[g-1];
      end
      if (g == CAPACITY - 1) begin : g_last
         assign right_value = cell_data[g];
      end else begin : g_inner_r
         assign right_value = cell_data[g+1];
      end
      plist_cell #(
         .INDEX (g),
         .IW    (IW)
      ) u_cell (
         .clock       (clock),
         .ctrl        (ctrl),
         .pos         (pos_ext),
         .rd_idx      (rd_idx),
         .ins_value   (req_value),
         .left_value  (left_value),
         .right_value (right_value),
         .value       (cell_data[g]),
         .sel_value   (cell_sel[g])
      );
   end

   always_comb begin
      sel_or = '0;
      for (int i = 0; i < CAPACITY; i++) begin
         sel_or = sel_or | cell_sel[i];
      end
   end

   always_comb begin
      count_in  = count_ff;
      dump_in   = dump_ff;
      idx_in    = idx_ff;
      ctrl      = '0;
      strobe_in = 1'b0;
      data_in   = '0;
      valid_in  = 1'b0;
      status_in = ST_DONE;
      last_in   = 1'b1;
      if (dump_ff) begin
         strobe_in = 1'b1;
         data_in   = sel_or;
         valid_in  = 1'b1;
         last_in   = (idx_ext == cnt_ext - 1'b1);
         if (last_in) begin
            dump_in = 1'b0;
            idx_in  = '0;
         end else begin
            idx_in = idx_ff + 1'b1;
         end
      end else if (accept) begin
         strobe_in = 1'b1;
         unique case (req_operation)
            OP_INSERT: begin
               if (pos_ext > cnt_ext) begin
                  status_in = ST_RANGE;
               end else if (count_ff == CW'(CAPACITY)) begin
                  status_in = ST_FULL;
               end else begin
                  ctrl.ins = 1'b1;
                  count_in = count_ff + 1'b1;
               end
            end
            OP_REMOVE: begin
               if (pos_ext >= cnt_ext) begin
                  status_in = ST_RANGE;
               end else begin
                  ctrl.rem = 1'b1;
                  count_in = count_ff - 1'b1;
               end
            end
            OP_QUERY: begin
               if (pos_ext >= cnt_ext) begin
                  status_in = ST_RANGE;
               end else begin
                  data_in  = sel_or;
                  valid_in = 1'b1;
               end
            end
            OP_DUMP: begin
               if (count_ff != '0) begin
                  strobe_in = 1'b0;
                  dump_in   = 1'b1;
                  idx_in    = '0;
               end
            end
            default: begin
               strobe_in = 1'b0;
            end
         endcase
      end
   end

   assign len_wide = IW'(count_in);
   assign len_in   = len_wide[6:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff  <= '0;
         dump_ff   <= 1'b0;
         idx_ff    <= '0;
         strobe_ff <= 1'b0;
      end else begin
         count_ff  <= count_in;
         dump_ff   <= dump_in;
         idx_ff    <= idx_in;
         strobe_ff <= strobe_in;
      end
   end

   always_ff @(posedge clock) begin
      data_ff   <= data_in;
      valid_ff  <= valid_in;
      len_ff    <= len_in;
      status_ff <= status_in;
      last_ff   <= last_in;
   end

   assign rsp_strobe      = strobe_ff;
   assign rsp_data_value  = data_ff;
   assign rsp_data_valid  = valid_ff;
   assign rsp_list_length = len_ff;
   assign rsp_status      = status_ff;
   assign rsp_last_of_run = last_ff;

   `PLIST_ASSERT(a_count_bound, count_ff <= CW'(CAPACITY), "element count above capacity")
   `PLIST_ASSERT(a_nonlast_busy, !(rsp_strobe && !rsp_last_of_run) || busy, "dump beat ended early")
   `PLIST_ASSERT_NEXT(a_single_beat, accept && req_operation != OP_DUMP, rsp_strobe && rsp_last_of_run, "missing result beat")
   `PLIST_ASSERT(a_error_no_data, !(rsp_strobe && rsp_status != ST_DONE) || !rsp_data_valid, "error beat carries data")
endmodule
`default_nettype wire

@@ tb/tb.sv @@
`timescale 1ns / 1ps
import plist_pkg::*;

class list_scoreboard #(int DEPTH = 64);
   typedef struct packed {
      logic signed [31:0] data;
      logic               valid;
      logic [6:0]         length;
      logic [1:0]         status;
      logic               last;
   } beat_type;

   logic signed [31:0] cells [DEPTH];
   int                 length;
   beat_type           pending_beats [$];
   int                 mismatches;

   function new();
      length = 0;
      mismatches = 0;
   endfunction

   function void queue_beat(logic signed [31:0] data, logic valid, logic [1:0] status,
                            logic last);
      beat_type b;
      b.data = data;
      b.valid = valid;
      b.length = length[6:0];
      b.status = status;
      b.last = last;
      pending_beats.push_back(b);
   endfunction

   function void apply_command(logic [1:0] op, logic [6:0] pos, logic signed [31:0] val);
      int p;
      p = pos;
      case (op)
         OP_INSERT: begin
            if (p > length) begin
               queue_beat(0, 1'b0, ST_RANGE, 1'b1);
            end else if (length >= DEPTH) begin
               queue_beat(0, 1'b0, ST_FULL, 1'b1);
            end else begin
               for (int i = length; i > p; i--) cells[i] = cells[i - 1];
               cells[p] = val;
               length++;
               queue_beat(0, 1'b0, ST_DONE, 1'b1);
            end
         end
         OP_REMOVE: begin
            if (p >= length) begin
               queue_beat(0, 1'b0, ST_RANGE, 1'b1);
            end else begin
               for (int i = p; i + 1 < length; i++) cells[i] = cells[i + 1];
               length--;
               queue_beat(0, 1'b0, ST_DONE, 1'b1);
            end
         end
         OP_QUERY: begin
            if (p >= length) begin
               queue_beat(0, 1'b0, ST_RANGE, 1'b1);
            end else begin
               queue_beat(cells[p], 1'b1, ST_DONE, 1'b1);
            end
         end
         default: begin
            if (length == 0) begin
               queue_beat(0, 1'b0, ST_DONE, 1'b1);
            end else begin
               for (int i = 0; i < length; i++)
                  queue_beat(cells[i], 1'b1, ST_DONE, i == length - 1);
            end
         end
      endcase
   endfunction

   function void note_mismatch(string what);
      mismatches++;
      if (mismatches <= 10) $display("MISMATCH at %0t: %s", $realtime, what);
   endfunction

   function void check_beat(logic signed [31:0] data, logic valid, logic [6:0] len,
                            logic [1:0] status, logic last);
      beat_type want;
      if (pending_beats.size() == 0) begin
         note_mismatch($sformatf("beat with nothing awaited: data %0d valid %0b status %0d",
                                 data, valid, status));
         return;
      end
      want = pending_beats.pop_front();
      if (want.data !== data)
         note_mismatch($sformatf("data_value expected %0d got %0d", want.data, data));
      if (want.valid !== valid)
         note_mismatch($sformatf("data_valid expected %0b got %0b", want.valid, valid));
      if (want.length !== len)
         note_mismatch($sformatf("list_length expected %0d got %0d", want.length, len));
      if (want.status !== status)
         note_mismatch($sformatf("status expected %0d got %0d", want.status, status));
      if (want.last !== last)
         note_mismatch($sformatf("last_of_run expected %0b got %0b", want.last, last));
   endfunction

   function int pending();
      return pending_beats.size();
   endfunction
endclass

module tb;
   localparam int CAPACITY = 64;

   typedef enum {GROW, SATURATE, SHRINK, MIXED} traffic_mode_type;

   logic               clock;
   logic               reset = 1'b1;
   logic               start = 1'b0;
   logic               busy;
   logic [1:0]         req_operation = OP_QUERY;
   logic [6:0]         req_position = '0;
   logic signed [31:0] req_value = '0;
   logic signed [31:0] rsp_data_value;
   logic               rsp_data_valid;
   logic [6:0]         rsp_list_length;
   logic [1:0]         rsp_status;
   logic               rsp_last_of_run;
   logic               rsp_strobe;

   list_scoreboard #(CAPACITY) book;
   bit idling_on = 1'b1;

   positional_list_engine_unit #(.CAPACITY(CAPACITY)) DUT (
      .clock(clock),
      .reset(reset),
      .start(start),
      .busy(busy),
      .req_operation(req_operation),
      .req_position(req_position),
      .req_value(req_value),
      .rsp_data_value(rsp_data_value),
      .rsp_data_valid(rsp_data_valid),
      .rsp_list_length(rsp_list_length),
      .rsp_status(rsp_status),
      .rsp_last_of_run(rsp_last_of_run),
      .rsp_strobe(rsp_strobe)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   initial begin
      #5000000;
      $display("tb NOT OK");
      $finish;
   end

   always @(posedge clock) begin
      if (!reset && rsp_strobe)
         book.check_beat(rsp_data_value, rsp_data_valid, rsp_list_length, rsp_status,
                         rsp_last_of_run);
   end

   task automatic issue_command(logic [1:0] op, logic [6:0] pos, logic signed [31:0] val);
      while (idling_on && $urandom_range(99) < 9) begin
         start <= 1'b0;
         @(posedge clock);
      end
      start <= 1'b1;
      req_operation <= op;
      req_position <= pos;
      req_value <= val;
      do @(posedge clock); while (busy);
      book.apply_command(op, pos, val);
   endtask

   task automatic wait_for_drain();
      start <= 1'b0;
      do @(posedge clock); while (book.pending() > 0);
   endtask

   function automatic logic [1:0] pick_op(int ins_w, int rem_w, int qry_w);
      int r;
      r = $urandom_range(99);
      if (r < ins_w) return OP_INSERT;
      if (r < ins_w + rem_w) return OP_REMOVE;
      if (r < ins_w + rem_w + qry_w) return OP_QUERY;
      return OP_DUMP;
   endfunction

   function automatic logic [6:0] pick_position(logic [1:0] op);
      int len;
      len = book.length;
      if (op == OP_INSERT)
         return ($urandom_range(99) < 85) ? 7'($urandom_range(len))
                                          : 7'($urandom_range(CAPACITY));
      if (len > 0 && $urandom_range(99) < 85) return 7'($urandom_range(len - 1));
      return 7'($urandom_range(CAPACITY));
   endfunction

   function automatic logic signed [31:0] pick_value();
      case ($urandom_range(39))
         0: return 32'sh8000_0000;
         1: return 32'sh7fff_ffff;
         2: return 0;
         3: return -1;
         default: return $urandom;
      endcase
   endfunction

   initial begin
      traffic_mode_type   mode;
      int                 dwell;
      logic [1:0]         op;
      logic [6:0]         pos;

      book = new();
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      issue_command(OP_DUMP, 0, 0);
      issue_command(OP_QUERY, 0, 0);
      issue_command(OP_REMOVE, 0, 0);
      issue_command(OP_INSERT, 1, 5);
      issue_command(OP_INSERT, 0, 32'sh8000_0000);
      issue_command(OP_INSERT, 1, 32'sh7fff_ffff);
      issue_command(OP_INSERT, 1, 0);
      issue_command(OP_INSERT, 0, -1);
      issue_command(OP_QUERY, 0, 0);
      issue_command(OP_QUERY, 3, 0);
      issue_command(OP_QUERY, 4, 0);
      issue_command(OP_DUMP, 0, 0);
      issue_command(OP_REMOVE, 4, 0);
      issue_command(OP_REMOVE, 1, 0);
      issue_command(OP_QUERY, 64, 0);
      issue_command(OP_INSERT, 64, 32'sh5a5a_a5a5);
      issue_command(OP_REMOVE, 64, 0);
      issue_command(OP_REMOVE, 2, 0);
      issue_command(OP_REMOVE, 0, 0);
      issue_command(OP_DUMP, 0, 0);
      issue_command(OP_REMOVE, 0, 0);
      issue_command(OP_DUMP, 0, 0);
      wait_for_drain();

      mode = GROW;
      dwell = 0;
      for (int n = 0; n < 300; n++) begin
         idling_on = (n < 120 || n >= 200);
         if (n == 210) wait_for_drain();
         if (mode == GROW && book.length == CAPACITY) mode = SATURATE;
         if (mode == SATURATE && dwell >= 12) mode = SHRINK;
         if (mode == SHRINK && book.length <= 2) mode = MIXED;
         case (mode)
            GROW:     op = pick_op(75, 8, 10);
            SATURATE: op = pick_op(60, 10, 20);
            SHRINK:   op = pick_op(8, 75, 10);
            default:  op = pick_op(35, 30, 25);
         endcase
         pos = pick_position(op);
         if (mode == SATURATE) begin
            dwell++;
            if (op == OP_INSERT && $urandom_range(1)) pos = 7'(book.length);
         end
         issue_command(op, pos, pick_value());
      end

      wait_for_drain();
      repeat (10) @(posedge clock);
      if (book.mismatches == 0 && book.pending() == 0) begin
         $display("tb OK");
      end else begin
         $display("tb NOT OK");
      end
      $finish;
   end
endmodule
